// ===== hw/rtl/text_pattern_match_finder_top_defines.svh =====
// assertion macros for the pattern match finder
// used by text_pattern_match_finder_top, expects clk_i and rst_ni in scope
`ifndef TEXT_PATTERN_MATCH_FINDER_TOP_DEFINES_SVH
`define TEXT_PATTERN_MATCH_FINDER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TPMF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TPMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tpmf_pkg.sv =====
// shared types, codes and helpers of the pattern match finder
// no dependencies
package tpmf_pkg;

  // window depth, fixed by the 64-bit pattern register
  localparam int unsigned MAX_PATTERN = 8;
  localparam int unsigned SEL_W       = $clog2(MAX_PATTERN);
  localparam int unsigned LEN_W       = 4;

  // parameter defaults
  localparam int unsigned MATCH_CAP_DEF   = 1000;
  localparam int unsigned LINE_LENGTH_DEF = 4096;

  // output field widths
  localparam int unsigned LINE_W   = 16;
  localparam int unsigned COLUMN_W = 12;
  localparam int unsigned NUMBER_W = 10;

  // command codes
  localparam logic [1:0] CMD_TEXT = 2'd0;
  localparam logic [1:0] CMD_EOL  = 2'd1;
  localparam logic [1:0] CMD_NEW  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_LENGTH  = 2'd1;
  localparam logic [1:0] REG_CASE    = 2'd2;

  // ascii bounds for folding
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // one result beat
  typedef struct packed {
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic [NUMBER_W-1:0] number;
  } tpmf_result_t;

  // result handed from the tracker to the output buffer
  typedef struct packed {
    logic         push;
    tpmf_result_t result;
  } tpmf_push_t;

  // fold A-Z to lower case unless comparing exactly
  function automatic logic [7:0] fold_char(logic [7:0] c, logic case_sens);
    logic [7:0] r;
    r = c;
    if (!case_sens && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/text_pattern_match_finder_top.sv =====
// top level of the streaming pattern match finder
// depends on tpmf_pkg, tpmf_cell, tpmf_ctrl, tpmf_skid and the defines header
//
//  channel  handshake                 payload
//  in       in_valid_i / in_stall_o   command_i, text_byte_i
//  out      out_valid_o / out_stall_i match_line_o, match_column_o, match_number_o
//  cfg      cfg_we_i                  cfg_index_i, cfg_data_i
//
// one input beat per cycle unless stalled; each match is held in the output buffer
// the window compare runs in parallel across the cell row, so only stalls hold bytes
// in_stall_o rises only while both the output register and the skid stage hold beats
// reset clears window and counters; pattern 0, length 1, case folding on
`include "text_pattern_match_finder_top_defines.svh"

module text_pattern_match_finder_top
  import tpmf_pkg::*;
#(
  parameter int unsigned MATCH_CAP   = MATCH_CAP_DEF,
  parameter int unsigned LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [7:0]          text_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LINE_W-1:0]   match_line_o,
  output logic [COLUMN_W-1:0] match_column_o,
  output logic [NUMBER_W-1:0] match_number_o
);

  logic [63:0]      pattern_q;
  logic [LEN_W-1:0] length_q;
  logic             case_q;
  logic             in_acc, text_acc, new_acc;
  logic [LEN_W-1:0] eff_len;
  logic [7:0]       pat_arr [MAX_PATTERN];
  logic [7:0]       win_q   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_match;
  logic             window_hit;
  tpmf_push_t       push;
  tpmf_result_t     out_data;
  logic             full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LEN_W'(1);
      case_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PATTERN: pattern_q <= cfg_data_i;
        REG_LENGTH:  length_q  <= cfg_data_i[LEN_W-1:0];
        REG_CASE:    case_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign text_acc = in_acc && (command_i == CMD_TEXT);
  assign new_acc  = in_acc && (command_i == CMD_NEW);

  // overlong lengths use the full window
  assign eff_len = (length_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : length_q;

  // row of window cells, newest byte in cell 0
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [SEL_W-1:0] sel;
    logic [7:0]       feed;
    logic             in_use;

    assign pat_arr[i] = pattern_q[8*i +: 8];
    assign in_use     = LEN_W'(i) < eff_len;
    assign sel        = SEL_W'(eff_len - LEN_W'(1) - LEN_W'(i));

    if (i == 0) begin : g_head
      assign feed = text_byte_i;
    end else begin : g_body
      assign feed = win_q[i-1];
    end

    tpmf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (text_acc),
      .clear_i     (new_acc),
      .byte_i      (feed),
      .pattern_i   (pat_arr[sel]),
      .case_sens_i (case_q),
      .in_use_i    (in_use),
      .byte_o      (win_q[i]),
      .match_o     (cell_match[i])
    );
  end

  assign window_hit = &cell_match;

  // counters and match decision
  tpmf_ctrl #(
    .MATCH_CAP   (MATCH_CAP),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .command_i    (command_i),
    .eff_len_i    (eff_len),
    .window_hit_i (window_hit),
    .push_o       (push)
  );

  // output register with skid stage
  tpmf_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .full_o      (full)
  );

  assign in_stall_o     = full;
  assign match_line_o   = out_data.line;
  assign match_column_o = out_data.column;
  assign match_number_o = out_data.number;

  // checks
  `TPMF_ASSERT_IMPL(a_skid_needs_main, in_stall_o, out_valid_o, "skid full without output beat")
  `TPMF_ASSERT_NEXT(a_push_shows, push.push, out_valid_o, "pushed result not visible")
  `TPMF_ASSERT_IMPL(a_only_text_hits, in_acc && (command_i != CMD_TEXT), !push.push,
                    "result from a non-text beat")

endmodule

// ===== hw/rtl/tpmf_cell.sv =====
// one window cell: holds a recent text byte and compares its next value
// depends on tpmf_pkg
module tpmf_cell
  import tpmf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pattern_i,
  input  logic       case_sens_i,
  input  logic       in_use_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q;

  // byte storage, shifted from the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (clear_i) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // compare the byte this cell takes on now against its pattern character
  assign match_o = !in_use_i ||
                   (fold_char(byte_i, case_sens_i) == fold_char(pattern_i, case_sens_i));
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/tpmf_ctrl.sv =====
// position and match tracking: column, line, overlap guard, match count
// depends on tpmf_pkg
module tpmf_ctrl
  import tpmf_pkg::*;
#(
  parameter int unsigned MATCH_CAP   = MATCH_CAP_DEF,
  parameter int unsigned LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       command_i,
  input  logic [LEN_W-1:0] eff_len_i,
  input  logic             window_hit_i,
  output tpmf_push_t       push_o
);

  localparam int unsigned CW = $clog2(LINE_LENGTH);
  localparam int unsigned MW = $clog2(MATCH_CAP + 1);
  localparam logic [CW-1:0] COL_MAX = CW'(LINE_LENGTH - 1);
  localparam logic [MW-1:0] MATCH_MAX = MW'(MATCH_CAP);

  logic [CW-1:0]    col_q, col_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [LEN_W-1:0] guard_q, guard_d;
  logic [MW-1:0]    count_q, count_d;
  logic [LEN_W-1:0] guard_dec;
  logic [CW:0]      col_plus;
  logic [CW-1:0]    start;
  logic             hit;

  assign guard_dec = (guard_q != '0) ? guard_q - LEN_W'(1) : '0;
  assign col_plus  = {1'b0, col_q} + (CW+1)'(1);

  // match decision for a text byte
  assign hit = accept_i && (command_i == CMD_TEXT) && (eff_len_i != '0) &&
               (guard_dec == '0) && (count_q < MATCH_MAX) &&
               (col_plus >= (CW+1)'(eff_len_i)) && window_hit_i;

  // start column, pinned while the column is saturated
  assign start = (col_q < COL_MAX) ? CW'(col_plus - (CW+1)'(eff_len_i)) : COL_MAX;

  // next-state of the counters
  always_comb begin
    col_d   = col_q;
    line_d  = line_q;
    guard_d = guard_q;
    count_d = count_q;
    if (accept_i) begin
      unique case (command_i)
        CMD_TEXT: begin
          if (col_q < COL_MAX) begin
            col_d = col_q + CW'(1);
          end
          if (hit) begin
            count_d = count_q + MW'(1);
            guard_d = eff_len_i;
          end else begin
            guard_d = guard_dec;
          end
        end
        CMD_EOL: begin
          if (line_q != '1) begin
            line_d = line_q + LINE_W'(1);
          end
          col_d   = '0;
          guard_d = '0;
        end
        CMD_NEW: begin
          col_d   = '0;
          line_d  = '0;
          guard_d = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      line_q  <= '0;
      guard_q <= '0;
      count_q <= '0;
    end else begin
      col_q   <= col_d;
      line_q  <= line_d;
      guard_q <= guard_d;
      count_q <= count_d;
    end
  end

  // result beat for the output buffer
  assign push_o.push          = hit;
  assign push_o.result.line   = line_q;
  assign push_o.result.column = COLUMN_W'(start);
  assign push_o.result.number = NUMBER_W'(count_q);

endmodule

// ===== hw/rtl/tpmf_skid.sv =====
// two-entry output buffer: output register plus skid stage
// depends on tpmf_pkg
module tpmf_skid
  import tpmf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tpmf_push_t   push_i,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output tpmf_result_t out_data_o,
  output logic         full_o
);

  logic         main_v_q, skid_v_q;
  tpmf_result_t main_q, skid_q;
  logic         pop;

  assign pop = main_v_q && !out_stall_i;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i.push;
      end
    end else if (push_i.push) begin
      if (main_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      main_q <= skid_v_q ? skid_q : push_i.result;
    end else if (push_i.push) begin
      if (main_v_q) begin
        skid_q <= push_i.result;
      end else begin
        main_q <= push_i.result;
      end
    end
  end

  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;
  assign full_o      = skid_v_q;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of text_pattern_match_finder_top: directed and random beats
// depends on tpmf_pkg and text_pattern_match_finder_top
// a match tracker class predicts every match and checks output beats in arrival order
module testbench;
  import tpmf_pkg::*;

  localparam int unsigned MATCH_LIMIT  = MATCH_CAP_DEF;
  localparam int unsigned COLUMN_LAST  = LINE_LENGTH_DEF - 1;
  localparam int unsigned LINE_LAST    = 65535;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned ROUND_BEATS  = 45;

  // predicts matches from accepted beats and checks the output stream
  class match_tracker;
    tpmf_result_t expected_matches[$];
    int unsigned  errors;
    logic [63:0]  pat_bytes;
    logic [3:0]   pat_len;
    logic         exact;
    logic [7:0]   window[MAX_PATTERN];
    int unsigned  column;
    int unsigned  line;
    int unsigned  guard;
    int unsigned  found;

    function new();
      errors    = 0;
      pat_bytes = '0;
      pat_len   = 4'd1;
      exact     = 1'b0;
      clear_search();
    endfunction

    function void clear_search();
      foreach (window[k]) window[k] = '0;
      column = 0;
      line   = 0;
      guard  = 0;
      found  = 0;
    endfunction

    function logic [7:0] to_lower(logic [7:0] c);
      if (!exact && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
        return c + CASE_OFFSET;
      end
      return c;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        REG_PATTERN: pat_bytes = data;
        REG_LENGTH:  pat_len = data[3:0];
        REG_CASE:    exact = data[0];
        default: ;
      endcase
    endfunction

    // advance the search by one accepted beat, queue a match if it ends here
    function void note_beat(logic [1:0] cmd, logic [7:0] b);
      int unsigned  len;
      int unsigned  col_before;
      int unsigned  k;
      bit           hit;
      tpmf_result_t m;
      if (cmd == CMD_NEW) begin
        clear_search();
        return;
      end
      if (cmd == CMD_EOL) begin
        if (line < LINE_LAST) line++;
        column = 0;
        guard  = 0;
        return;
      end
      if (cmd != CMD_TEXT) return;

      // shift the window, newest byte in entry 0
      for (k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;

      col_before = column;
      if (column < COLUMN_LAST) column++;
      if (guard > 0) guard--;

      len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
      if (len == 0 || guard != 0 || found >= MATCH_LIMIT) return;
      if (col_before + 1 < len) return;

      // pattern character 0 lines up with the oldest byte of the window
      hit = 1'b1;
      for (k = 0; k < len; k++) begin
        if (to_lower(pat_bytes[8*k +: 8]) != to_lower(window[len-1-k])) hit = 1'b0;
      end
      if (!hit) return;

      m.line   = line[LINE_W-1:0];
      m.column = (col_before < COLUMN_LAST) ? COLUMN_W'(col_before + 1 - len)
                                            : COLUMN_W'(COLUMN_LAST);
      m.number = found[NUMBER_W-1:0];
      expected_matches.push_back(m);
      found++;
      guard = len;
    endfunction

    // compare one output beat with the oldest predicted match
    function void check_match(logic [LINE_W-1:0] ln, logic [COLUMN_W-1:0] col,
                              logic [NUMBER_W-1:0] num);
      tpmf_result_t want;
      if (expected_matches.size() == 0) begin
        $error("match beat with none pending: line %0d column %0d number %0d", ln, col, num);
        errors++;
        return;
      end
      want = expected_matches.pop_front();
      if (ln !== want.line) begin
        $error("match_line expected %0d actual %0d", want.line, ln);
        errors++;
      end
      if (col !== want.column) begin
        $error("match_column expected %0d actual %0d", want.column, col);
        errors++;
      end
      if (num !== want.number) begin
        $error("match_number expected %0d actual %0d", want.number, num);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [1:0]          cfg_index_i = REG_PATTERN;
  logic [63:0]         cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [1:0]          command_i   = CMD_TEXT;
  logic [7:0]          text_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LINE_W-1:0]   match_line_o;
  logic [COLUMN_W-1:0] match_column_o;
  logic [NUMBER_W-1:0] match_number_o;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  cycle_count   = 0;
  match_tracker tracker;

  text_pattern_match_finder_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .text_byte_i    (text_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_line_o   (match_line_o),
    .match_column_o (match_column_o),
    .match_number_o (match_number_o)
  );

  // clock, period 8
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_match(match_line_o, match_column_o, match_number_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    text_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_beat(cmd, b);
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_beat(CMD_TEXT, s[k]);
  endtask

  // wait until every predicted match is out and the pipeline is empty
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (tracker.expected_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // all three registers, once idle; unused upper bits carry noise
  task automatic set_search(input logic [63:0] pat, input logic [3:0] len, input logic ex);
    logic [63:0] data;
    wait_quiet();
    cfg_write(REG_PATTERN, pat);
    data      = {$urandom, $urandom};
    data[3:0] = len;
    cfg_write(REG_LENGTH, data);
    data      = {$urandom, $urandom};
    data[0]   = ex;
    cfg_write(REG_CASE, data);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] pack_pattern(input string s);
    logic [63:0] p;
    int          k;
    p = '0;
    for (k = 0; k < s.len() && k < MAX_PATTERN; k++) p[8*k +: 8] = s[k];
    return p;
  endfunction

  // mostly pattern copies and pattern characters, the rest noise and commands
  task automatic random_round(input int unsigned n);
    int unsigned sent;
    int unsigned eff;
    int unsigned pick;
    int unsigned k;
    logic [7:0]  b;
    sent = 0;
    eff  = (tracker.pat_len > MAX_PATTERN) ? MAX_PATTERN : tracker.pat_len;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 30 && eff != 0) begin
        // whole pattern, letter case flipped now and then
        for (k = 0; k < eff; k++) begin
          b = tracker.pat_bytes[8*k +: 8];
          if ((b | CASE_OFFSET) >= 8'h61 && (b | CASE_OFFSET) <= 8'h7A
              && $urandom_range(3) == 0) begin
            b = b ^ CASE_OFFSET;
          end
          send_beat(CMD_TEXT, b);
        end
        sent += eff;
      end else if (pick < 65 && eff != 0) begin
        k = $urandom_range(eff - 1);
        send_beat(CMD_TEXT, tracker.pat_bytes[8*k +: 8]);
        sent++;
      end else if (pick < 90) begin
        send_beat(CMD_TEXT, 8'($urandom_range(255)));
        sent++;
      end else if (pick < 96) begin
        send_beat(CMD_EOL, 8'($urandom_range(255)));
        sent++;
      end else if (pick < 98) begin
        send_beat(CMD_NEW, 8'($urandom_range(255)));
        sent++;
      end else begin
        send_beat(CMD_UNUSED, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [63:0] pat;
    logic [3:0]  len;
    int unsigned k;
    int          phase;
    int          round;
    tracker = new();
    send_idle_pct = 23;
    recv_idle_pct = 69;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: pattern byte zero, length one
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);

    // case folding, unused command, no match across a line end
    set_search(pack_pattern("AbC"), 4'd3, 1'b0);
    send_text("aBc");
    send_beat(CMD_UNUSED, 8'hA5);
    send_text("xAB");
    send_beat(CMD_EOL, 8'h00);
    send_text("C");

    // exact compare, no overlapping matches
    set_search(pack_pattern("aa"), 4'd2, 1'b1);
    send_beat(CMD_NEW, 8'h5A);
    send_text("aaaaA");

    // overlong length acts as the full window
    set_search('1, 4'd15, 1'b1);
    repeat (8) send_beat(CMD_TEXT, 8'hFF);

    // empty pattern never matches, unused register index ignored
    set_search('1, 4'd0, 1'b0);
    wait_quiet();
    cfg_write(REG_UNUSED, '1);
    cfg_we_i <= 1'b0;
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_NEW, 8'h00);

    // random part over three idling phases
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (round = 0; round < 3; round++) begin
        if (phase == 2 && round == 0) begin
          set_search('1, 4'd8, 1'b1);
        end else if (phase == 2 && round == 1) begin
          set_search('0, 4'd1, 1'b0);
        end else begin
          // letters mostly, so folding and matches come often
          for (k = 0; k < MAX_PATTERN; k++) begin
            if ($urandom_range(3) == 0) pat[8*k +: 8] = 8'($urandom_range(255));
            else if ($urandom_range(1) == 0) pat[8*k +: 8] = 8'($urandom_range(8'h41, 8'h44));
            else pat[8*k +: 8] = 8'($urandom_range(8'h61, 8'h64));
          end
          k = $urandom_range(99);
          if (k < 5) len = 4'd0;
          else if (k < 15) len = 4'($urandom_range(9, 15));
          else len = 4'($urandom_range(1, 8));
          set_search(pat, len, 1'($urandom_range(1)));
        end
        random_round(ROUND_BEATS);
      end
    end

    wait_quiet();
    if (tracker.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
